// ===== rtl/wpo_pkg.sv =====
package wpo_pkg;

  // Coordinate width of every position and offset field (signed, two's complement).
  localparam int CoordWidth = 32;

  // The first points of a lane that pass through unchanged.
  localparam logic [1:0] PassCount = 2'd2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] offset_magn;
    logic                         lane_end;
  } wpo_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] out_x;
    logic signed [CoordWidth-1:0] out_y;
    logic                         degenerate;
    logic                         lane_last;
  } wpo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_PRODUCT,
    ST_DIVIDE,
    ST_FINISH
  } wpo_state_t;

endpackage

// ===== rtl/waypoint_perpendicular_offset_top.sv =====
// Perpendicular offset of a waypoint stream.
// Input channel (in_valid/in_ready/in_data): one waypoint per transaction, with x, y,
// offset magnitude and the end-of-lane mark. Output channel (out_valid/out_ready/out_data):
// exactly one result per waypoint, in order.
// The first two points of a lane leave unchanged, going from idle straight to the finishing
// step. A later point goes through a radix-2 sequencer with W = 32 bit coordinate width:
// two bit-serial squarers, one sum step, a digit-by-digit square root, two bit-serial
// multipliers and two restoring dividers sharing the root as divisor, then a saturating
// add for each coordinate. A zero-length segment stops after the root.
// One waypoint is worked on at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next waypoint is taken while it waits.
// If the receiver stalls and the next result is ready, the sequencer holds it until the
// output register frees up.
// Reset (rst_n low, synchronous) empties the output register, returns the sequencer to idle
// and clears the stored previous point and the lane point count.
module waypoint_perpendicular_offset_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wpo_pkg::wpo_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wpo_pkg::wpo_out_t out_data
);
  import wpo_pkg::*;

  localparam int W = CoordWidth;
  localparam int CntW = $clog2(W + 2);
  localparam logic [CntW-1:0] MulSteps  = CntW'(W - 1);
  localparam logic [CntW-1:0] RootSteps = CntW'(W);

  // Sequencer and stream state.
  wpo_state_t      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [1:0]      point_count_r, point_count_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working registers of the current waypoint.
  logic [W-1:0]    x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [W-1:0]    mag_m_r, mag_m_nxt, dmag_x_r, dmag_x_nxt, dmag_y_r, dmag_y_nxt;
  logic            neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic            last_r, last_nxt, keep_r, keep_nxt, degen_r, degen_nxt;
  logic [W:0]      hi_r [2];
  logic [W:0]      hi_nxt [2];
  logic [W-1:0]    lo_r [2];
  logic [W-1:0]    lo_nxt [2];
  logic [2*W+1:0]  s_r, s_nxt;
  logic [W:0]      root_r, root_nxt;
  logic [W+1:0]    srem_r, srem_nxt;
  wpo_out_t        out_data_r, out_data_nxt;

  // Combinational helpers.
  logic            accept;
  logic [W:0]      dx_full, dy_full, dx_abs, dy_abs;
  logic [W-1:0]    m_abs;
  logic [W-1:0]    mc [2];
  logic [W:0]      mul_sum [2];
  logic [W+1:0]    div_sh [2];
  logic [W+1:0]    div_diff [2];
  logic            div_ge [2];
  logic [W+3:0]    rt_sh, rt_trial, rt_diff;
  logic            rt_ge;
  logic [W:0]      root_step;
  logic [W+1:0]    srem_step;

  // Adds a signed base and a signed quotient term, saturating to the coordinate range.
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] base, input logic [W-1:0] q,
                                           input logic neg);
    logic [W+1:0] b_ext;
    logic [W+1:0] q_ext;
    logic [W+1:0] sum;
    b_ext = {{2{base[W-1]}}, base};
    q_ext = neg ? (~{2'b00, q} + 1'b1) : {2'b00, q};
    sum   = b_ext + q_ext;
    if (sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111) begin
      return sum[W-1:0];
    end else if (sum[W+1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Segment differences and magnitudes, taken straight from the incoming waypoint.
  always_comb begin
    dx_full = {in_data.pos_x[W-1], in_data.pos_x} - {prev_x_r[W-1], prev_x_r};
    dy_full = {in_data.pos_y[W-1], in_data.pos_y} - {prev_y_r[W-1], prev_y_r};
    dx_abs  = dx_full[W] ? (~dx_full + 1'b1) : dx_full;
    dy_abs  = dy_full[W] ? (~dy_full + 1'b1) : dy_full;
    m_abs   = in_data.offset_magn[W-1] ? (~in_data.offset_magn + 1'b1) : in_data.offset_magn;
  end

  // One shift-add multiply step and one restoring divide step in each of the two lanes.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mc[i] = (state_r == ST_SQUARE) ? ((i == 0) ? dmag_x_r : dmag_y_r) : mag_m_r;
      mul_sum[i]  = {1'b0, hi_r[i][W-1:0]} + (lo_r[i][0] ? {1'b0, mc[i]} : '0);
      div_sh[i]   = {hi_r[i], lo_r[i][W-1]};
      div_ge[i]   = (div_sh[i] >= {1'b0, root_r});
      div_diff[i] = div_sh[i] - {1'b0, root_r};
    end
  end

  // One digit-by-digit square root step: two radicand bits in, one root bit out.
  always_comb begin
    rt_sh     = {srem_r, s_r[2*W+1:2*W]};
    rt_trial  = {1'b0, root_r, 2'b01};
    rt_ge     = (rt_sh >= rt_trial);
    rt_diff   = rt_sh - rt_trial;
    root_step = {root_r[W-1:0], rt_ge};
    srem_step = rt_ge ? rt_diff[W+1:0] : rt_sh[W+1:0];
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    point_count_nxt = point_count_r;
    out_valid_nxt   = out_valid_r;
    x1_nxt          = x1_r;
    y1_nxt          = y1_r;
    x2_nxt          = x2_r;
    y2_nxt          = y2_r;
    mag_m_nxt       = mag_m_r;
    dmag_x_nxt      = dmag_x_r;
    dmag_y_nxt      = dmag_y_r;
    neg_x_nxt       = neg_x_r;
    neg_y_nxt       = neg_y_r;
    last_nxt        = last_r;
    keep_nxt        = keep_r;
    degen_nxt       = degen_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    s_nxt           = s_r;
    root_nxt        = root_r;
    srem_nxt        = srem_r;
    out_data_nxt    = out_data_r;

    // The output register empties when its transaction is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x1_nxt     = prev_x_r;
          y1_nxt     = prev_y_r;
          x2_nxt     = in_data.pos_x;
          y2_nxt     = in_data.pos_y;
          last_nxt   = in_data.lane_end;
          keep_nxt   = (point_count_r < PassCount);
          degen_nxt  = 1'b0;
          mag_m_nxt  = m_abs;
          dmag_x_nxt = dx_abs[W-1:0];
          dmag_y_nxt = dy_abs[W-1:0];
          neg_x_nxt  = in_data.offset_magn[W-1] ^ dy_full[W];
          neg_y_nxt  = ~in_data.offset_magn[W-1] ^ dx_full[W];
          hi_nxt[0]  = '0;
          hi_nxt[1]  = '0;
          lo_nxt[0]  = dx_abs[W-1:0];
          lo_nxt[1]  = dy_abs[W-1:0];
          cnt_nxt    = MulSteps;
          prev_x_nxt = in_data.pos_x;
          prev_y_nxt = in_data.pos_y;
          if (in_data.lane_end) begin
            point_count_nxt = '0;
          end else if (point_count_r < PassCount) begin
            point_count_nxt = point_count_r + 2'd1;
          end
          state_nxt = (point_count_r < PassCount) ? ST_FINISH : ST_SQUARE;
        end
      end

      // Squares of both differences, or products of the magnitude with both differences, one multiplier bit per cycle.
      ST_SQUARE, ST_PRODUCT: begin
        for (int i = 0; i < 2; i++) begin
          hi_nxt[i] = {1'b0, mul_sum[i][W:1]};
          lo_nxt[i] = {mul_sum[i][0], lo_r[i][W-1:1]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = MulSteps;
          state_nxt = (state_r == ST_SQUARE) ? ST_SUM : ST_DIVIDE;
        end
      end

      ST_SUM: begin
        s_nxt    = {1'b0, (2*W+1)'({hi_r[0][W-1:0], lo_r[0]})
                          + (2*W+1)'({hi_r[1][W-1:0], lo_r[1]})};
        root_nxt = '0;
        srem_nxt = '0;
        cnt_nxt  = RootSteps;
        state_nxt = ST_ROOT;
      end

      // Segment length; a zero root means a zero-length segment.
      ST_ROOT: begin
        s_nxt    = {s_r[2*W-1:0], 2'b00};
        root_nxt = root_step;
        srem_nxt = srem_step;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (root_step == '0) begin
            degen_nxt = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            hi_nxt[0] = '0;
            hi_nxt[1] = '0;
            lo_nxt[0] = dmag_y_r;
            lo_nxt[1] = dmag_x_r;
            cnt_nxt   = MulSteps;
            state_nxt = ST_PRODUCT;
          end
        end
      end

      // Quotient bits shift into the low half as dividend bits leave it.
      ST_DIVIDE: begin
        for (int i = 0; i < 2; i++) begin
          hi_nxt[i] = div_ge[i] ? div_diff[i][W:0] : div_sh[i][W:0];
          lo_nxt[i] = {lo_r[i][W-2:0], div_ge[i]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.lane_last  = last_r;
          out_data_nxt.degenerate = degen_r;
          if (keep_r || degen_r) begin
            out_data_nxt.out_x = x2_r;
            out_data_nxt.out_y = y2_r;
          end else begin
            out_data_nxt.out_x = sat_add(x1_r, lo_r[0], neg_x_r);
            out_data_nxt.out_y = sat_add(y1_r, lo_r[1], neg_y_r);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      point_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      prev_x_r      <= prev_x_nxt;
      prev_y_r      <= prev_y_nxt;
      point_count_r <= point_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    mag_m_r    <= mag_m_nxt;
    dmag_x_r   <= dmag_x_nxt;
    dmag_y_r   <= dmag_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    last_r     <= last_nxt;
    keep_r     <= keep_nxt;
    degen_r    <= degen_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    s_r        <= s_nxt;
    root_r     <= root_nxt;
    srem_r     <= srem_nxt;
    out_data_r <= out_data_nxt;
  end

  // The divisor is never zero while dividing, and each partial remainder stays below it.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE |-> root_r != '0)
    else $error("divide entered with a zero segment length");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE |-> (hi_r[0] < root_r) && (hi_r[1] < root_r))
    else $error("partial remainder not below the divisor");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    point_count_r <= PassCount)
    else $error("lane point count beyond its limit");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared without a finishing step");

endmodule

// ===== sim/wpo_offset_checker.sv =====
module wpo_offset_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  wpo_pkg::wpo_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  wpo_pkg::wpo_out_t out_data,
  output int                error_count,
  output int                outstanding
);

  localparam int W = wpo_pkg::CoordWidth;
  localparam longint CoordMax = (longint'(1) <<< (W - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;

  // Previous original point and position within the current lane.
  logic signed [W-1:0] last_x;
  logic signed [W-1:0] last_y;
  logic [1:0]          lane_pos;

  wpo_pkg::wpo_out_t predicted_results[$];
  int                errors;

  // Saturate a wide sum to the signed coordinate range.
  function automatic logic [W-1:0] clamp_coord(input longint v);
    longint r;
    r = (v > CoordMax) ? CoordMax : ((v < CoordMin) ? CoordMin : v);
    return r[W-1:0];
  endfunction

  // One component of magn * d / seg_len, truncated toward zero, with the sign of
  // the magnitude and of the segment component combined.
  function automatic longint normal_term(input logic [127:0] magn_abs, input bit magn_neg,
                                         input longint d, input logic [127:0] seg_len);
    logic [127:0] d_abs;
    logic [127:0] quot;
    d_abs = (d < 0) ? 128'(-d) : 128'(d);
    quot = (magn_abs * d_abs) / seg_len;
    return (magn_neg != (d < 0)) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
  endfunction

  // Expected result for one waypoint, given the previous original point.
  function automatic wpo_pkg::wpo_out_t offset_waypoint(input wpo_pkg::wpo_in_t p,
                                                        input longint px, input longint py,
                                                        input bit passing);
    wpo_pkg::wpo_out_t r;
    longint            dx;
    longint            dy;
    longint            m;
    logic [127:0]      a;
    logic [127:0]      b;
    logic [127:0]      sq;
    logic [127:0]      seg_len;
    logic [127:0]      trial;
    int                k;
    r.out_x      = p.pos_x;
    r.out_y      = p.pos_y;
    r.degenerate = 1'b0;
    r.lane_last  = p.lane_end;
    if (!passing) begin
      dx = longint'($signed(p.pos_x)) - px;
      dy = longint'($signed(p.pos_y)) - py;
      a  = (dx < 0) ? 128'(-dx) : 128'(dx);
      b  = (dy < 0) ? 128'(-dy) : 128'(dy);
      sq = a * a + b * b;
      // Exact floor square root, one bit at a time from the top.
      seg_len = '0;
      for (k = W + 1; k >= 0; k--) begin
        trial = seg_len | (128'd1 << k);
        if (trial * trial <= sq) seg_len = trial;
      end
      if (seg_len == 0) begin
        r.degenerate = 1'b1;
      end else begin
        m = longint'($signed(p.offset_magn));
        a = (m < 0) ? 128'(-m) : 128'(m);
        r.out_x = clamp_coord(px + normal_term(a, m < 0, dy, seg_len));
        r.out_y = clamp_coord(py + normal_term(a, !(m < 0), dx, seg_len));
      end
    end
    return r;
  endfunction

  task automatic report_field(input string field, input logic signed [63:0] exp_v,
                              input logic signed [63:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    errors++;
  endtask

  // Watch both channels: retire results first, then predict the new transaction.
  always @(posedge clk) begin
    wpo_pkg::wpo_out_t exp_r;
    if (!rst_n) begin
      last_x   = '0;
      last_y   = '0;
      lane_pos = '0;
      errors   = 0;
      predicted_results.delete();
      error_count <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d degenerate=%0b last=%0b", $time,
                   out_data.out_x, out_data.out_y, out_data.degenerate, out_data.lane_last);
          errors++;
        end else begin
          exp_r = predicted_results.pop_front();
          if (out_data.out_x !== exp_r.out_x)
            report_field("out_x", exp_r.out_x, out_data.out_x);
          if (out_data.out_y !== exp_r.out_y)
            report_field("out_y", exp_r.out_y, out_data.out_y);
          if (out_data.degenerate !== exp_r.degenerate)
            report_field("degenerate", exp_r.degenerate, out_data.degenerate);
          if (out_data.lane_last !== exp_r.lane_last)
            report_field("lane_last", exp_r.lane_last, out_data.lane_last);
        end
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(offset_waypoint(in_data, last_x, last_y,
                                                    lane_pos < wpo_pkg::PassCount));
        last_x = in_data.pos_x;
        last_y = in_data.pos_y;
        if (lane_pos < wpo_pkg::PassCount) lane_pos++;
        if (in_data.lane_end) lane_pos = '0;
      end
      error_count <= errors;
      outstanding <= predicted_results.size();
    end
  end

endmodule

// ===== sim/waypoint_perpendicular_offset_top_tb.sv =====
module waypoint_perpendicular_offset_top_tb;

  import wpo_pkg::*;

  localparam int W            = CoordWidth;
  localparam int U            = 65536;
  localparam int PointsWanted = 1150;
  localparam int CycleLimit   = 1_000_000;
  localparam int HoldCycles   = 600;
  localparam int SettleCycles = 150;
  localparam logic signed [W-1:0] CoordTop    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CoordBottom = {1'b1, {(W-1){1'b0}}};

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  wpo_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  wpo_out_t out_data;
  int       error_count;
  int       outstanding;
  int       points_sent;
  bit       calm;
  bit       hold_request;

  waypoint_perpendicular_offset_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  wpo_offset_checker offset_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the cycle count.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("waypoint_perpendicular_offset_top_tb: FAIL");
    $finish;
  end

  // Random step of a random scale, from a single unit up to the full range.
  function automatic logic signed [W-1:0] scaled_step();
    logic signed [W-1:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, W - 1);
  endfunction

  // Offer one waypoint after a random idle gap (none while calm) and hold it until the transaction.
  task automatic offer_waypoint(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                                input logic signed [W-1:0] m, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pos_x: x, pos_y: y, offset_magn: m, lane_end: last};
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One lane as a random walk: mostly small steps, some jumps, repeated points
  // and extremes. A tidy lane carries its end mark on the last point only.
  task automatic run_lane(input int len, input bit tidy);
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] m;
    int                  pick;
    int                  i;
    logic                last;
    x = $urandom;
    y = $urandom;
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        x = $urandom_range(0, 1) ? CoordTop : CoordBottom;
        y = $urandom_range(0, 1) ? CoordTop : CoordBottom;
      end else if (pick < 3) begin
        // Same point again gives a zero-length segment.
      end else if (pick < 6) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = x + scaled_step();
        y = y + scaled_step();
      end
      case ($urandom_range(0, 15))
        0:       m = CoordTop;
        1:       m = CoordBottom;
        2:       m = '0;
        default: m = scaled_step();
      endcase
      last = tidy ? (i == len - 1) : ($urandom_range(0, 3) == 0);
      offer_waypoint(x, y, m, last);
    end
  endtask

  // Result side: random stalls, one long hold-off when asked.
  initial begin
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int lane_len;
    bit hold_done;
    bit pause_done;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    points_sent  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Pass-through points, an ordinary offset, a zero-length segment, full-range
    // segments with extreme magnitudes, and a degenerate point closing the lane.
    offer_waypoint(0, 0, 0, 1'b0);
    offer_waypoint(100 * U, 0, 3 * U, 1'b0);
    offer_waypoint(200 * U, 50 * U, 5 * U, 1'b0);
    offer_waypoint(200 * U, 50 * U, -7 * U, 1'b0);
    offer_waypoint(-300 * U, 20 * U, CoordTop, 1'b0);
    offer_waypoint(CoordBottom, CoordBottom, CoordBottom, 1'b0);
    offer_waypoint(CoordTop, CoordTop, CoordBottom, 1'b0);
    offer_waypoint(CoordTop, CoordTop, 0, 1'b1);
    // A lane of one point, then a lane of two.
    offer_waypoint(CoordBottom, CoordTop, CoordTop, 1'b1);
    offer_waypoint(1, 1, CoordTop, 1'b0);
    offer_waypoint(-1, -1, CoordBottom, 1'b1);
    // Degenerate third point, unit segments with extreme magnitudes, and
    // saturation at both ends of the x range.
    offer_waypoint(0, 0, 0, 1'b0);
    offer_waypoint(0, 0, 0, 1'b0);
    offer_waypoint(0, 0, U, 1'b0);
    offer_waypoint(1, 0, CoordTop, 1'b0);
    offer_waypoint(0, 1, CoordBottom, 1'b0);
    offer_waypoint(CoordTop, 0, U, 1'b0);
    offer_waypoint(CoordTop, 100, CoordTop, 1'b0);
    offer_waypoint(CoordBottom, 0, U, 1'b0);
    offer_waypoint(CoordBottom, -100, CoordTop, 1'b1);
    drain_results();

    // Random lanes, mostly well formed; a long result stall and a full pause midway.
    while (points_sent < PointsWanted) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      if (!hold_done && points_sent >= 400) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && points_sent >= 800) begin
        drain_results();
        pause_done = 1'b1;
      end
      lane_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
      run_lane(lane_len, $urandom_range(0, 7) != 0);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("waypoint_perpendicular_offset_top_tb: PASS");
    end else begin
      $display("waypoint_perpendicular_offset_top_tb: FAIL");
    end
    $finish;
  end

endmodule
